### rtl/ple_pkg.sv
// Shared constants, operation and status codes and beat types for the positional list engine.
// No dependencies; the engine and its checker import it.
package ple_pkg;

    // Storage depth of the list and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the beats.
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_AT    = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] item_value;
        logic signed [POS_W-1:0]   position;
    } ple_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic signed [VALUE_W-1:0] read_value;
    } ple_out_t;

endpackage

### rtl/positional_list_engine.sv
// Top level of the positional list engine: a list held in a circular buffer in one memory.
// Depends on ple_pkg for the beat types, codes and the capacity.
//
//  Channel   Ports                          Carries
//  input     s_valid, s_ready, s_payload    one operation beat (ple_in_t)
//  result    m_valid, m_ready, m_payload    one result beat per operation (ple_out_t)
//
// Each operation ends by reading the front, the back and the read position from memory before
// its result beat is registered. An insert or remove first moves the entries behind it one at a
// time through the memory, but a new front only moves the head back and a removed front the
// head on; the next beat can be accepted in the same cycle as a result beat appears.
// Reset (aresetn low, synchronous) empties the list at once; the memory is not cleared.
// A stalled result waits in its output register while the next operation is worked on.
module positional_list_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ple_pkg::ple_in_t s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output ple_pkg::ple_out_t m_payload
);
    import ple_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SRD  = 9'b000000010,
        S_SWR  = 9'b000000100,
        S_PUT  = 9'b000001000,
        S_RD0  = 9'b000010000,
        S_RD1  = 9'b000100000,
        S_RD2  = 9'b001000000,
        S_RD3  = 9'b010000000,
        S_OUT  = 9'b100000000
    } ple_state_t;

    // Maps a list position to a memory address: head plus position, wrapped once.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                              input logic [CNT_W-1:0] l);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(h) + (CNT_W+1)'(l);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    // The list storage: one write port and one read port, read data registered.
    logic [VALUE_W-1:0] mem [CAPACITY];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [VALUE_W-1:0] mem_wd;
    logic [IDX_W-1:0]   mem_ra;
    logic [VALUE_W-1:0] rd_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[mem_ra];
    end

    ple_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    // Entry being moved, and where the move stops (also the insert position).
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    bound_reg, bound_next;
    logic                up_reg, up_next;
    logic [VALUE_W-1:0]  put_val_reg, put_val_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  front_reg, front_next;
    logic [VALUE_W-1:0]  back_reg, back_next;
    logic [VALUE_W-1:0]  rdv_reg, rdv_next;
    logic                m_valid_reg, m_valid_next;
    ple_out_t            m_payload_reg, m_payload_next;

    // Decoding of the incoming position against the current count.
    logic             full, empty;
    logic             pos_le0, pos_ge_cnt, pos_ge_last;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] ins_idx, rem_idx;
    logic [IDX_W-1:0] head_dec, head_inc;

    always_comb begin
        full        = (count_reg == CNT_W'(CAPACITY));
        empty       = (count_reg == '0);
        count_m1    = count_reg - CNT_W'(1);
        pos_le0     = s_payload.position[POS_W-1] || (s_payload.position == '0);
        pos_ge_cnt  = !s_payload.position[POS_W-1]
                      && ($unsigned(s_payload.position) >= POS_W'(count_reg));
        pos_ge_last = !s_payload.position[POS_W-1]
                      && ($unsigned(s_payload.position) >= POS_W'(count_m1));
        head_dec    = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
        head_inc    = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + IDX_W'(1);

        if (s_payload.operation == OP_PUSH_FRONT) begin
            ins_idx = '0;
        end else if (s_payload.operation == OP_PUSH_BACK) begin
            ins_idx = count_reg;
        end else if (pos_le0) begin
            ins_idx = '0;
        end else if (pos_ge_cnt) begin
            ins_idx = count_reg;
        end else begin
            ins_idx = s_payload.position[CNT_W-1:0];
        end

        if (s_payload.operation == OP_POP_FRONT) begin
            rem_idx = '0;
        end else if (s_payload.operation == OP_POP_BACK) begin
            rem_idx = count_m1;
        end else if (pos_le0) begin
            rem_idx = '0;
        end else if (pos_ge_last) begin
            rem_idx = count_m1;
        end else begin
            rem_idx = s_payload.position[CNT_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        bound_next     = bound_reg;
        up_next        = up_reg;
        put_val_next   = put_val_reg;
        rd_idx_next    = rd_idx_reg;
        rd_ok_next     = rd_ok_reg;
        status_next    = status_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        rdv_next       = rdv_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    status_next  = ST_OK;
                    rd_ok_next   = 1'b0;
                    rd_idx_next  = '0;
                    put_val_next = s_payload.item_value;
                    state_next   = S_RD0;
                    unique case (s_payload.operation) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                up_next    = 1'b1;
                                idx_next   = count_reg;
                                bound_next = ins_idx;
                                if (ins_idx == '0) begin
                                    // A new front only moves the head back.
                                    head_next  = head_dec;
                                    state_next = S_PUT;
                                end else begin
                                    state_next = S_SRD;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                up_next    = 1'b0;
                                idx_next   = rem_idx;
                                bound_next = count_m1;
                                if (rem_idx == '0) begin
                                    head_next  = head_inc;
                                    count_next = count_m1;
                                end else begin
                                    state_next = S_SRD;
                                end
                            end
                        end
                        OP_READ_AT: begin
                            if (!s_payload.position[POS_W-1] && !pos_ge_cnt) begin
                                rd_ok_next  = 1'b1;
                                rd_idx_next = s_payload.position[CNT_W-1:0];
                            end else begin
                                status_next = ST_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (idx_reg == bound_reg) begin
                    if (up_reg) begin
                        state_next = S_PUT;
                    end else begin
                        count_next = count_m1;
                        state_next = S_RD0;
                    end
                end else begin
                    mem_ra     = phys(head_reg, up_reg ? idx_reg - CNT_W'(1)
                                                      : idx_reg + CNT_W'(1));
                    state_next = S_SWR;
                end
            end
            S_SWR: begin
                mem_we     = 1'b1;
                mem_wa     = phys(head_reg, idx_reg);
                mem_wd     = rd_data;
                idx_next   = up_reg ? idx_reg - CNT_W'(1) : idx_reg + CNT_W'(1);
                state_next = S_SRD;
            end
            S_PUT: begin
                mem_we     = 1'b1;
                mem_wa     = phys(head_reg, bound_reg);
                mem_wd     = put_val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_RD0;
            end
            S_RD0: begin
                mem_ra     = phys(head_reg, '0);
                state_next = S_RD1;
            end
            S_RD1: begin
                mem_ra     = phys(head_reg, count_m1);
                front_next = empty ? '0 : rd_data;
                state_next = S_RD2;
            end
            S_RD2: begin
                mem_ra     = phys(head_reg, rd_idx_reg);
                back_next  = empty ? '0 : rd_data;
                state_next = S_RD3;
            end
            S_RD3: begin
                rdv_next   = rd_ok_reg ? rd_data : '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_payload_next.status      = status_reg;
                    m_payload_next.entry_count = COUNT_W'(count_reg);
                    m_payload_next.front_value = front_reg;
                    m_payload_next.back_value  = back_reg;
                    m_payload_next.read_value  = rdv_reg;
                    m_valid_next               = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers carry no reset.
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        bound_reg     <= bound_next;
        up_reg        <= up_next;
        put_val_reg   <= put_val_next;
        rd_idx_reg    <= rd_idx_next;
        rd_ok_reg     <= rd_ok_next;
        status_reg    <= status_next;
        front_reg     <= front_next;
        back_reg      <= back_next;
        rdv_reg       <= rdv_next;
        m_payload_reg <= m_payload_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

### rtl/ple_checker.sv
// Port-level checks on the positional list engine, attached by a bind statement below.
// Depends on ple_pkg and on the port names of positional_list_engine.
module ple_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input ple_pkg::ple_out_t m_payload
);
    import ple_pkg::*;

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat dropped or changed while stalled");

    // The count never exceeds the capacity.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.entry_count <= COUNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // An empty list reports zero at both ends.
    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.entry_count == '0
            |-> m_payload.front_value == '0 && m_payload.back_value == '0)
        else $error("empty list reports a front or back value");

    // A failed operation returns no read value.
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != ST_OK |-> m_payload.read_value == '0)
        else $error("read value on a failed operation");

    // A full-list rejection can only report a full list.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status == ST_FULL
            |-> m_payload.entry_count == COUNT_W'(CAPACITY))
        else $error("full status with room left");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

### tb/tb.sv
// Self-checking testbench for positional_list_engine: directed table, then random list traffic.
// Depends on ple_pkg and the engine RTL; a shadow list predicts results not typed by hand.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    // The operation code that the package leaves unnamed; the engine must treat it as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int DIRECTED_N       = 25;
    localparam int RANDOM_PER_PHASE = 510;
    localparam int MODE_RUN         = 40;      // beats before the traffic mix is re-drawn
    localparam int HOLD_CYCLES      = 300;     // long receiver hold-off in the last phase
    localparam int DRAIN_CYCLES     = 80;      // allowance for the longest operation
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int MAX_REPORTS      = 10;

    // Traffic mixes: growing the list towards full, shrinking it, or anything at all.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } list_mix_e;

    // One row of the directed table. Where typed is set, res is the result written by hand;
    // otherwise the row is checked against the shadow list.
    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] val;
        logic signed [POS_W-1:0]   pos;
        bit                        typed;
        ple_out_t                  res;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    ple_in_t   s_payload;
    logic      m_valid;
    logic      m_ready;
    ple_out_t  m_payload;

    // Shadow of the list contents and occupancy, updated as each input beat is accepted.
    logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
    int                        shadow_count = 0;

    // Results still owed by the engine, oldest first.
    ple_out_t    expected_results [$];
    int          error_count  = 0;
    int unsigned cycle_count  = 0;

    // Idle rates in percent for each side, and the request for one long receiver hold-off.
    int tx_idle_pct  = 12;
    int rx_stall_pct = 78;
    bit hold_req     = 1'b0;

    positional_list_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // The directed table. It starts from an empty list, so every pop, remove and read in the
    // first rows must report empty or out of range, with zeros everywhere else. The two pushes
    // of the extreme values can also be read off directly. The middle of the table walks the
    // insert and remove clamps at both ends and in the middle, and the read range checks.
    stim_row_t directed_rows [DIRECTED_N] = '{
        '{OP_POP_FRONT,  32'sd7,          16'sd0,      1'b1, '{ST_EMPTY, 5'd0, 0, 0, 0}},
        '{OP_POP_BACK,   32'sd7,          16'sd0,      1'b1, '{ST_EMPTY, 5'd0, 0, 0, 0}},
        '{OP_REMOVE_AT,  32'sd7,          16'sd3,      1'b1, '{ST_EMPTY, 5'd0, 0, 0, 0}},
        '{OP_READ_AT,    32'sd0,          16'sd0,      1'b1, '{ST_RANGE, 5'd0, 0, 0, 0}},
        '{OP_UNUSED,     -32'sd1,         -16'sd1,     1'b1, '{ST_OK,    5'd0, 0, 0, 0}},
        '{OP_PUSH_BACK,  32'sh7FFF_FFFF,  16'sd0,      1'b1,
          '{ST_OK, 5'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0}},
        '{OP_PUSH_FRONT, 32'sh8000_0000,  16'sd0,      1'b1,
          '{ST_OK, 5'd2, 32'sh8000_0000, 32'sh7FFF_FFFF, 0}},
        '{OP_INSERT_AT,  32'sd1,          16'sh8000,   1'b0, '0},
        '{OP_INSERT_AT,  -32'sd1,         16'sh7FFF,   1'b0, '0},
        '{OP_INSERT_AT,  32'sh5555_5555,  16'sd2,      1'b0, '0},
        '{OP_INSERT_AT,  32'shAAAA_AAAA,  16'sd0,      1'b0, '0},
        '{OP_INSERT_AT,  32'sh0F0F_0F0F,  16'sd6,      1'b0, '0},
        '{OP_READ_AT,    32'sd9,          16'sd0,      1'b0, '0},
        '{OP_READ_AT,    32'sd9,          16'sd6,      1'b0, '0},
        '{OP_READ_AT,    32'sd9,          16'sd7,      1'b0, '0},
        '{OP_READ_AT,    32'sd9,          -16'sd1,     1'b0, '0},
        '{OP_READ_AT,    32'sd9,          16'sh8000,   1'b0, '0},
        '{OP_REMOVE_AT,  32'sd9,          16'sd3,      1'b0, '0},
        '{OP_REMOVE_AT,  32'sd9,          16'sh8000,   1'b0, '0},
        '{OP_REMOVE_AT,  32'sd9,          16'sh7FFF,   1'b0, '0},
        '{OP_REMOVE_AT,  32'sd9,          16'sd3,      1'b0, '0},
        '{OP_UNUSED,     32'sd9,          16'sd2,      1'b0, '0},
        '{OP_POP_FRONT,  32'sh1234_5678,  16'sd1,      1'b0, '0},
        '{OP_POP_BACK,   32'sh1234_5678,  16'sd1,      1'b0, '0},
        '{OP_REMOVE_AT,  32'sd9,          16'sd0,      1'b0, '0}
    };

    // Applies one operation to the shadow list and returns the result beat it should produce.
    // Pushes ignore the position; insert and remove clamp theirs to the ends. Pushes into a
    // full list and pops from an empty one leave the list alone and only set the status.
    function automatic ple_out_t apply_list_op(ple_in_t beat);
        ple_out_t res;
        int       pos;
        int       slot;
        int       i;
        res  = '0;
        pos  = {{(32-POS_W){beat.position[POS_W-1]}}, beat.position};
        slot = 0;
        res.status = ST_OK;
        case (beat.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    if (beat.operation == OP_PUSH_FRONT) begin
                        slot = 0;
                    end else if (beat.operation == OP_PUSH_BACK) begin
                        slot = shadow_count;
                    end else if (pos <= 0) begin
                        slot = 0;
                    end else if (pos >= shadow_count) begin
                        slot = shadow_count;
                    end else begin
                        slot = pos;
                    end
                    for (i = shadow_count; i > slot; i--) begin
                        shadow_list[i] = shadow_list[i-1];
                    end
                    shadow_list[slot] = beat.item_value;
                    shadow_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (beat.operation == OP_POP_FRONT) begin
                        slot = 0;
                    end else if (beat.operation == OP_POP_BACK) begin
                        slot = shadow_count - 1;
                    end else if (pos <= 0) begin
                        slot = 0;
                    end else if (pos >= shadow_count - 1) begin
                        slot = shadow_count - 1;
                    end else begin
                        slot = pos;
                    end
                    for (i = slot; i + 1 < shadow_count; i++) begin
                        shadow_list[i] = shadow_list[i+1];
                    end
                    shadow_count--;
                end
            end
            OP_READ_AT: begin
                if (pos >= 0 && pos < shadow_count) begin
                    res.read_value = shadow_list[pos];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = COUNT_W'(shadow_count);
        if (shadow_count != 0) begin
            res.front_value = shadow_list[0];
            res.back_value  = shadow_list[shadow_count-1];
        end
        return res;
    endfunction

    // Draws one random operation beat. The mix decides whether the list tends to grow or
    // shrink, so that it swings between empty and full; positions mostly land just around
    // the occupied range, with some fully random and some at the 16-bit extremes.
    function automatic ple_in_t make_list_beat(list_mix_e mix);
        ple_in_t beat;
        int      roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                beat.operation = roll < 30 ? OP_PUSH_BACK  :
                                 roll < 50 ? OP_PUSH_FRONT :
                                 roll < 75 ? OP_INSERT_AT  :
                                 roll < 87 ? OP_READ_AT    :
                                 roll < 93 ? OP_REMOVE_AT  :
                                 roll < 97 ? OP_POP_FRONT  : OP_UNUSED;
            end
            MIX_DRAIN: begin
                beat.operation = roll < 25 ? OP_POP_FRONT  :
                                 roll < 45 ? OP_POP_BACK   :
                                 roll < 75 ? OP_REMOVE_AT  :
                                 roll < 87 ? OP_READ_AT    :
                                 roll < 93 ? OP_INSERT_AT  :
                                 roll < 97 ? OP_PUSH_BACK  : OP_UNUSED;
            end
            default: begin
                beat.operation = OP_W'($urandom_range(7));
            end
        endcase

        roll = $urandom_range(9);
        case (roll)
            0:       beat.item_value = 32'sh8000_0000;
            1:       beat.item_value = 32'sh7FFF_FFFF;
            2:       beat.item_value = -32'sd1;
            3:       beat.item_value = 32'sd0;
            default: beat.item_value = $urandom();
        endcase

        roll = $urandom_range(9);
        if (roll < 7) begin
            beat.position = POS_W'(int'($urandom_range(shadow_count + 1)) - 1);
        end else if (roll == 7) begin
            beat.position = POS_W'($urandom());
        end else if (roll == 8) begin
            beat.position = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end else begin
            beat.position = POS_W'(shadow_count - 1);
        end
        return beat;
    endfunction

    // Offers one beat from a falling edge, with random idle cycles first, and holds it until
    // it is taken. The shadow list is updated at the accepting edge, so the next beat is drawn
    // from the list as it will be when the engine reaches it. Returns on a falling edge.
    task automatic send_beat(input ple_in_t beat, input bit typed, input ple_out_t typed_res);
        ple_out_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_list_op(beat);
        expected_results.push_back(typed ? typed_res : predicted);
        @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input ple_out_t want, input ple_out_t got);
        if (error_count < MAX_REPORTS) begin
            $write("%0t: %s: expected st=%0d cnt=%0d front=%0d back=%0d rd=%0d, ",
                   $realtime, what,
                   want.status, want.entry_count, want.front_value, want.back_value,
                   want.read_value);
            $display("got st=%0d cnt=%0d front=%0d back=%0d rd=%0d",
                     got.status, got.entry_count, got.front_value, got.back_value,
                     got.read_value);
        end
        error_count++;
    endtask

    // Clock: 4 ns period.
    initial begin : clock_gen
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run guard: a run that does not finish before the limit is stopped and reported as an error.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side. Ready is redrawn at every falling edge at the current stall rate. When a
    // hold-off is requested, ready stays low until the count kept here runs out, so the engine
    // fills its output register and its working stage and has to stall its input.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Every result beat is compared, field by field, with the oldest outstanding prediction.
    always @(posedge aclk) begin
        ple_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("result beat with nothing outstanding", '0, m_payload);
            end else begin
                want = expected_results.pop_front();
                if (m_payload.status      !== want.status      ||
                    m_payload.entry_count !== want.entry_count ||
                    m_payload.front_value !== want.front_value ||
                    m_payload.back_value  !== want.back_value  ||
                    m_payload.read_value  !== want.read_value) begin
                    note_mismatch("result mismatch", want, m_payload);
                end
            end
        end
    end

    initial begin : stimulus
        ple_in_t   beat;
        list_mix_e mix;
        int        row;
        int        phase;
        int        n;

        mix       = MIX_FILL;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;

        // Reset first; the shadow list starts empty, as the engine does.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, with the sender idling lightly and the receiver heavily.
        for (row = 0; row < DIRECTED_N; row++) begin
            beat.operation  = directed_rows[row].op;
            beat.item_value = directed_rows[row].val;
            beat.position   = directed_rows[row].pos;
            send_beat(beat, directed_rows[row].typed, directed_rows[row].res);
        end

        // Random part in three phases: first a slow receiver, then a slow sender, then neither,
        // but for one long receiver hold-off. Before each phase the sender stops and waits until
        // every result has come back, so the engine is seen starting again from idle.
        for (phase = 0; phase < 3; phase++) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while (expected_results.size() != 0);

            case (phase)
                0: begin
                    tx_idle_pct  = 12;
                    rx_stall_pct = 78;
                end
                1: begin
                    tx_idle_pct  = 78;
                    rx_stall_pct = 12;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    // The sender keeps offering beats through this hold-off.
                    hold_req     = 1'b1;
                end
            endcase

            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % MODE_RUN == 0) begin
                    mix = list_mix_e'($urandom_range(2));
                end
                beat = make_list_beat(mix);
                send_beat(beat, 1'b0, '0);
            end
        end

        // Let the engine drain, then allow the longest operation time for any stray beat.
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
